// ----- rtl/ssa_pkg.sv -----
// Shared types, constants and codes for the stack slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package ssa_pkg;

   localparam int SLOT_COUNT = 128;
   localparam int SLOT_BYTES = 65536;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
   localparam int ADDR_W     = 48;
   localparam logic [ADDR_W-1:0] SLOT_BYTES_A = ADDR_W'(SLOT_BYTES);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_ADDR_W-4:0] REG_STACK_BASE = '0;

   localparam logic [1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [1:0] FUNC_BIND    = 2'd1;
   localparam logic [1:0] FUNC_RELEASE = 2'd2;
   localparam logic [1:0] FUNC_FIND    = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NOMATCH = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [6:0]  slot_index;
      logic [30:0] os_thread_id;
      logic [63:0] thread_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [6:0]        found_slot;
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] end_addr;
   } rsp_type;

   typedef struct packed {
      logic [63:0] handle;
      logic [31:0] os_id;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      entry_type         data;
   } ram_wr_type;

endpackage
`default_nettype wire

// ----- rtl/ssa_slot_ram.sv -----
// Slot table memory holding the handle and OS id of every slot.
`timescale 1ns / 1ps
`default_nettype none
module ssa_slot_ram
   import ssa_pkg::*;
(
   input  wire logic              clock,
   input  wire ram_wr_type        wr,
   input  wire logic              rd_en,
   input  wire logic [SLOT_W-1:0] rd_addr,
   output      entry_type         rd_data
);

   entry_type mem [SLOT_COUNT];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/ssa_addr_gen.sv -----
// Stack start address of a slot: base plus slot number times slot size.
`timescale 1ns / 1ps
`default_nettype none
module ssa_addr_gen
   import ssa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic [SLOT_W-1:0] slot,
   input  wire logic [ADDR_W-1:0] base,
   output      logic [ADDR_W-1:0] start_addr
);

   logic [ADDR_W-1:0] start_ff;
   logic [ADDR_W-1:0] start_in;

   always_comb begin
      start_in = start_ff;
      if (load) begin
         start_in = base + ADDR_W'(slot) * SLOT_BYTES_A;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

   assign start_addr = start_ff;

endmodule
`default_nettype wire

// ----- rtl/ssa_seq.sv -----
// Operation sequencer: slot scan, in-use bits, table updates and result register.
`timescale 1ns / 1ps
`default_nettype none
module ssa_seq
   import ssa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire req_type           req,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      rsp_type           rsp,
   output      ram_wr_type        ram_wr,
   output      logic              rd_en,
   output      logic [SLOT_W-1:0] rd_addr,
   input  wire entry_type         rd_data,
   output      logic              addr_load,
   output      logic [SLOT_W-1:0] addr_slot,
   input  wire logic [ADDR_W-1:0] start_addr
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_RESULT = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [SLOT_COUNT-1:0] in_use_ff, in_use_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [SLOT_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [1:0]            func_ff, func_in;
   logic [30:0]           osid_ff, osid_in;
   logic [63:0]           handle_ff, handle_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic                  ok_ff, ok_in;
   logic [1:0]            status_ff, status_in;

   logic accept;
   logic hit;
   logic last;
   logic bind_ok;
   logic rsp_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign bind_ok   = (32'(req.slot_index) < 32'(SLOT_COUNT));
   assign last      = (chk_idx_ff == SLOT_W'(SLOT_COUNT - 1));
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // The table read for scan position cnt comes back in the next cycle and is
   // checked against the in-use bit of the same slot.
   assign rd_en   = (state_ff == S_SCAN) && (cnt_ff < CNT_W'(SLOT_COUNT));
   assign rd_addr = cnt_ff[SLOT_W-1:0];

   always_comb begin
      hit = 1'b0;
      case (func_ff)
         FUNC_ALLOC: begin
            hit = !in_use_ff[chk_idx_ff];
         end
         FUNC_RELEASE: begin
            hit = in_use_ff[chk_idx_ff] && (rd_data.handle == handle_ff);
         end
         FUNC_FIND: begin
            hit = in_use_ff[chk_idx_ff] && (rd_data.os_id == {1'b0, osid_ff});
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      in_use_in    = in_use_ff;
      cnt_in       = cnt_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      func_in      = func_ff;
      osid_in      = osid_ff;
      handle_in    = handle_ff;
      slot_in      = slot_ff;
      ok_in        = ok_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr       = '0;
      addr_load    = 1'b0;
      addr_slot    = slot_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in   = req.func;
               osid_in   = req.os_thread_id;
               handle_in = req.thread_handle;
               cnt_in    = '0;
               if (req.func == FUNC_BIND) begin
                  state_in  = S_RESULT;
                  ok_in     = bind_ok;
                  status_in = bind_ok ? ST_OK : ST_NOMATCH;
                  slot_in   = SLOT_W'(req.slot_index);
                  addr_load = 1'b1;
                  addr_slot = SLOT_W'(req.slot_index);
                  if (bind_ok) begin
                     ram_wr.en          = 1'b1;
                     ram_wr.addr        = SLOT_W'(req.slot_index);
                     ram_wr.data.handle = req.thread_handle;
                     ram_wr.data.os_id  = {1'b0, req.os_thread_id};
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               cnt_in       = cnt_ff + CNT_W'(1);
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_addr;
            end
            if (chk_valid_ff) begin
               if (hit) begin
                  state_in     = S_RESULT;
                  chk_valid_in = 1'b0;
                  ok_in        = 1'b1;
                  status_in    = ST_OK;
                  slot_in      = chk_idx_ff;
                  addr_load    = 1'b1;
                  addr_slot    = chk_idx_ff;
                  if (func_ff == FUNC_ALLOC) begin
                     in_use_in[chk_idx_ff] = 1'b1;
                     ram_wr.en             = 1'b1;
                     ram_wr.addr           = chk_idx_ff;
                     ram_wr.data.handle    = '1;
                     ram_wr.data.os_id     = '1;
                  end else if (func_ff == FUNC_RELEASE) begin
                     in_use_in[chk_idx_ff] = 1'b0;
                     ram_wr.en             = 1'b1;
                     ram_wr.addr           = chk_idx_ff;
                     ram_wr.data           = '0;
                  end
               end else if (last) begin
                  state_in     = S_RESULT;
                  chk_valid_in = 1'b0;
                  ok_in        = 1'b0;
                  status_in    = (func_ff == FUNC_ALLOC) ? ST_FULL : ST_NOMATCH;
               end
            end
         end
         S_RESULT: begin
            if (rsp_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (ok_ff) begin
                  rsp_in.status     = ST_OK;
                  rsp_in.found_slot = 7'(slot_ff);
                  rsp_in.start_addr = start_addr;
                  rsp_in.end_addr   = start_addr + SLOT_BYTES_A;
               end else begin
                  rsp_in.status     = status_ff;
                  rsp_in.found_slot = '0;
                  rsp_in.start_addr = '0;
                  rsp_in.end_addr   = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_use_ff    <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      chk_idx_ff <= chk_idx_in;
      func_ff    <= func_in;
      osid_ff    <= osid_in;
      handle_ff  <= handle_in;
      slot_ff    <= slot_in;
      ok_ff      <= ok_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/stack_slot_allocator_top.sv -----
// Top level of the stack slot allocator: register port and submodule wiring.
//
//   Port group   Direction  Handshake            Carries
//   req_*        in         req_valid/req_ready  operation, slot, OS id, handle
//   rsp_*        out        rsp_valid/rsp_ready  status, slot, stack bounds
//   csr_*        in/out     APB write/read       stack_base at byte address 0
//
// Bind goes from the transfer straight to the result state. Allocate, release
// and find scan the slot table one entry a cycle through its single read port,
// stopping at the first hit or, on a miss, after the last slot.
// Reset clears all in-use bits; the table memory itself is not cleared, since
// an entry is only compared while its slot is in use and allocate rewrites it.
// A result waits for a free output register; the next request is taken after that.
`timescale 1ns / 1ps
`default_nettype none
module stack_slot_allocator_top
   import ssa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire req_type               req,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      rsp_type               rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   logic [ADDR_W-1:0] base_ff, base_in;
   logic              base_sel;
   logic              csr_wr;

   ram_wr_type        ram_wr;
   logic              rd_en;
   logic [SLOT_W-1:0] rd_addr;
   entry_type         rd_data;
   logic              addr_load;
   logic [SLOT_W-1:0] addr_slot;
   logic [ADDR_W-1:0] start_addr;

   assign csr_pready = 1'b1;
   assign base_sel   = (csr_paddr[CSR_ADDR_W-1:3] == REG_STACK_BASE);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = base_sel ? CSR_DATA_W'(base_ff) : '0;

   always_comb begin
      base_in = base_ff;
      if (csr_wr && base_sel) begin
         base_in = csr_pwdata[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else begin
         base_ff <= base_in;
      end
   end

   ssa_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp),
      .ram_wr     (ram_wr),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .addr_load  (addr_load),
      .addr_slot  (addr_slot),
      .start_addr (start_addr)
   );

   ssa_slot_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ssa_addr_gen u_addr (
      .clock      (clock),
      .load       (addr_load),
      .slot       (addr_slot),
      .base       (base_ff),
      .start_addr (start_addr)
   );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the stack slot allocator: stimulus, prediction and checks.
`timescale 1ns / 1ps
module testbench;
   import ssa_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = SLOT_COUNT + 8;
   localparam logic [CSR_ADDR_W-4:0] REG_SPARE = ~REG_STACK_BASE;

   typedef struct packed {
      logic [SLOT_COUNT-1:0]        in_use;
      logic [SLOT_COUNT-1:0][63:0]  handle;
      logic [SLOT_COUNT-1:0][31:0]  os_id;
   } slot_table_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // The check table follows accepted transfers; the plan table runs ahead of
   // it and follows every queued operation, so the generator can aim at live slots.
   slot_table_type shadow_slots = '0;
   slot_table_type plan_slots   = '0;
   logic [ADDR_W-1:0] shadow_base = '0;

   req_type queued_slot_ops[$];
   rsp_type predicted_slot_rsps[$];

   logic [63:0] handle_pool [4];
   logic [30:0] os_id_pool [4];

   int  ops_queued = 0;
   int  ops_accepted = 0;
   int  errors = 0;
   int  idle_odds = 0;
   int  req_gap = 0;
   int  rsp_hold = 0;
   int  quiet_cycles = 0;
   int  full_count = 0;
   int  miss_count = 0;
   int  op_count [4] = '{0, 0, 0, 0};
   bit  req_accepted = 1'b0;

   stack_slot_allocator_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic apply_slot_op(inout slot_table_type t, input req_type op,
                                input logic [ADDR_W-1:0] base, output rsp_type res);
      logic hit;
      int   slot;
      hit = 1'b0;
      slot = 0;
      res = '0;
      case (op.func)
         FUNC_ALLOC: begin
            for (int i = 0; i < SLOT_COUNT && !hit; i++)
               if (!t.in_use[i]) begin
                  hit = 1'b1;
                  slot = i;
               end
            if (hit) begin
               t.in_use[slot] = 1'b1;
               t.handle[slot] = '1;
               t.os_id[slot] = '1;
            end
            res.status = hit ? ST_OK : ST_FULL;
         end
         FUNC_BIND: begin
            if (int'(op.slot_index) < SLOT_COUNT) begin
               hit = 1'b1;
               slot = int'(op.slot_index);
               t.handle[slot] = op.thread_handle;
               t.os_id[slot] = {1'b0, op.os_thread_id};
            end
            res.status = hit ? ST_OK : ST_NOMATCH;
         end
         FUNC_RELEASE: begin
            for (int i = 0; i < SLOT_COUNT && !hit; i++)
               if (t.in_use[i] && t.handle[i] == op.thread_handle) begin
                  hit = 1'b1;
                  slot = i;
               end
            if (hit) begin
               t.in_use[slot] = 1'b0;
               t.handle[slot] = '0;
               t.os_id[slot] = '0;
            end
            res.status = hit ? ST_OK : ST_NOMATCH;
         end
         default: begin
            for (int i = 0; i < SLOT_COUNT && !hit; i++)
               if (t.in_use[i] && t.os_id[i] == {1'b0, op.os_thread_id}) begin
                  hit = 1'b1;
                  slot = i;
               end
            res.status = hit ? ST_OK : ST_NOMATCH;
         end
      endcase
      if (hit) begin
         res.found_slot = 7'(slot);
         res.start_addr = base + ADDR_W'(slot) * SLOT_BYTES_A;
         res.end_addr = res.start_addr + SLOT_BYTES_A;
      end
   endtask

   task automatic plan_op(input req_type op);
      rsp_type ignored_rsp;
      apply_slot_op(plan_slots, op, '0, ignored_rsp);
      queued_slot_ops.push_back(op);
      ops_queued++;
   endtask

   task automatic plan_fields(input logic [1:0] code, input int slot,
                              input logic [30:0] os_id, input logic [63:0] handle);
      req_type op;
      op.func = code;
      op.slot_index = 7'(slot);
      op.os_thread_id = os_id;
      op.thread_handle = handle;
      plan_op(op);
   endtask

   // Returns a slot that will be in use once everything queued so far has run, or -1.
   function automatic int pick_used_slot();
      int first;
      int found;
      first = $urandom_range(0, SLOT_COUNT - 1);
      found = -1;
      for (int i = 0; i < SLOT_COUNT && found < 0; i++)
         if (plan_slots.in_use[(first + i) % SLOT_COUNT])
            found = (first + i) % SLOT_COUNT;
      return found;
   endfunction

   // Release, bind and find mostly aimed at live slots, with noise handles and ids mixed in.
   task automatic plan_random_op(input int alloc_pct, input int release_pct);
      req_type op;
      int      pick;
      int      slot;
      op.slot_index = 7'($urandom_range(0, SLOT_COUNT - 1));
      op.os_thread_id = 31'($urandom_range(0, 32'h7FFF_FFFF));
      op.thread_handle = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0)
         op.thread_handle = handle_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 3) == 0)
         op.os_thread_id = os_id_pool[$urandom_range(0, 3)];
      pick = $urandom_range(0, 99);
      slot = pick_used_slot();
      if (pick < alloc_pct) begin
         op.func = FUNC_ALLOC;
      end else if (pick < alloc_pct + release_pct) begin
         op.func = FUNC_RELEASE;
         if (slot >= 0 && $urandom_range(0, 9) != 0)
            op.thread_handle = plan_slots.handle[slot];
      end else if (pick < alloc_pct + release_pct + (100 - alloc_pct - release_pct) / 2) begin
         op.func = FUNC_BIND;
         if (slot >= 0 && $urandom_range(0, 7) != 0)
            op.slot_index = 7'(slot);
      end else begin
         op.func = FUNC_FIND;
         if (slot >= 0 && $urandom_range(0, 9) != 0)
            op.os_thread_id = plan_slots.os_id[slot][30:0];
      end
      plan_op(op);
   endtask

   task automatic csr_cycle(input logic wr, input logic [CSR_ADDR_W-4:0] index,
                            input logic [63:0] data, output logic [63:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= CSR_ADDR_W'({index, 3'b000});
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_stack_base(input logic [CSR_ADDR_W-4:0] index,
                                   input logic [63:0] value);
      logic [63:0] readback;
      csr_cycle(1'b1, index, value, readback);
      if (index == REG_STACK_BASE)
         shadow_base = value[ADDR_W-1:0];
      csr_cycle(1'b0, REG_STACK_BASE, '0, readback);
      if (readback[ADDR_W-1:0] !== shadow_base) begin
         $error("stack_base: expected %h, got %h", shadow_base, readback[ADDR_W-1:0]);
         errors++;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (ops_accepted != ops_queued || predicted_slot_rsps.size() != 0);
   endtask

   task automatic run_phase(input logic [63:0] base, input int odds, input int count,
                            input int alloc_pct, input int release_pct);
      wait_drained();
      repeat (4) @(negedge clock);
      write_stack_base(REG_STACK_BASE, base);
      idle_odds = odds;
      repeat (count) plan_random_op(alloc_pct, release_pct);
   endtask

   // Request driver: holds each item until its transfer, with random gaps between items.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (req_gap == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            req_gap = $urandom_range(1, 16);
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (queued_slot_ops.size() != 0) begin
            req <= queued_slot_ops.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_hold == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            rsp_hold = $urandom_range(1, 16);
         if (rsp_hold != 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: predicts on each request transfer and checks each result transfer.
   always @(posedge clock) begin
      rsp_type want;
      req_accepted = !reset && req_valid && req_ready;
      if (req_accepted) begin
         apply_slot_op(shadow_slots, req, shadow_base, want);
         predicted_slot_rsps.push_back(want);
         ops_accepted++;
         op_count[req.func]++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_slot_rsps.size() == 0) begin
            $error("unexpected result transfer: status %0d slot %0d", rsp.status,
                   rsp.found_slot);
            errors++;
         end else begin
            want = predicted_slot_rsps.pop_front();
            if (rsp.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp.status);
               errors++;
            end
            if (rsp.found_slot !== want.found_slot) begin
               $error("found_slot: expected %0d, got %0d", want.found_slot, rsp.found_slot);
               errors++;
            end
            if (rsp.start_addr !== want.start_addr) begin
               $error("start_addr: expected %h, got %h", want.start_addr, rsp.start_addr);
               errors++;
            end
            if (rsp.end_addr !== want.end_addr) begin
               $error("end_addr: expected %h, got %h", want.end_addr, rsp.end_addr);
               errors++;
            end
            if (want.status == ST_FULL)
               full_count++;
            if (want.status == ST_NOMATCH)
               miss_count++;
         end
      end
      if (req_accepted || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
         quiet_cycles = 0;
      else if (!reset)
         quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      handle_pool[0] = '1;
      handle_pool[1] = '0;
      handle_pool[2] = {$urandom, $urandom};
      handle_pool[3] = {$urandom, $urandom};
      os_id_pool[0] = '0;
      os_id_pool[1] = '1;
      os_id_pool[2] = 31'($urandom_range(0, 32'h7FFF_FFFF));
      os_id_pool[3] = 31'($urandom_range(0, 32'h7FFF_FFFF));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Base near the top of the address space so that slots one and two wrap.
      write_stack_base(REG_STACK_BASE, 64'h0000_FFFF_FFFE_0000);
      write_stack_base(REG_SPARE, {$urandom, $urandom});
      idle_odds = 12;
      plan_fields(FUNC_FIND, 0, '0, '0);
      plan_fields(FUNC_RELEASE, 0, '0, '0);
      plan_fields(FUNC_ALLOC, 0, '0, '0);
      plan_fields(FUNC_ALLOC, 0, '0, '0);
      plan_fields(FUNC_ALLOC, 0, '0, '0);
      plan_fields(FUNC_FIND, 0, '1, '0);
      plan_fields(FUNC_RELEASE, 0, '0, '1);
      plan_fields(FUNC_ALLOC, 0, '0, '0);
      plan_fields(FUNC_BIND, 0, '1, '1);
      plan_fields(FUNC_FIND, 0, '1, '0);
      plan_fields(FUNC_BIND, 1, '0, '0);
      plan_fields(FUNC_FIND, 0, '0, '0);
      plan_fields(FUNC_RELEASE, 0, '0, '0);
      plan_fields(FUNC_RELEASE, 0, '0, '0);
      // A bind to an idle slot is accepted but must stay invisible to lookups.
      plan_fields(FUNC_BIND, SLOT_COUNT - 1, 31'h2AAA_AAAA, 64'h5555_5555_5555_5555);
      plan_fields(FUNC_FIND, 0, 31'h2AAA_AAAA, '0);
      plan_fields(FUNC_RELEASE, 0, '0, 64'h5555_5555_5555_5555);
      plan_fields(FUNC_BIND, 2, 31'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      plan_fields(FUNC_FIND, 0, 31'h5555_5555, '0);
      plan_fields(FUNC_RELEASE, 0, '0, '1);
      plan_fields(FUNC_ALLOC, 0, '0, '0);
      plan_fields(FUNC_BIND, 0, 31'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      plan_fields(FUNC_FIND, 0, 31'h5555_5555, '0);
      plan_fields(FUNC_RELEASE, 0, '0, 64'hAAAA_AAAA_AAAA_AAAA);

      // Fill until the table runs full, drain, fill again, then a steady mix.
      run_phase(64'h0000_FFFF_FFFF_FFFF, 25, 320, 65, 8);
      run_phase({$urandom, $urandom}, 10, 300, 15, 40);
      run_phase(64'h0, 40, 260, 65, 8);
      run_phase({$urandom, $urandom}, 0, 260, 30, 30);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (predicted_slot_rsps.size() != 0) begin
         $error("%0d results never arrived", predicted_slot_rsps.size());
         errors++;
      end
      $display("testbench: %0d operations (allocate %0d, bind %0d, release %0d, find %0d)",
               ops_accepted, op_count[FUNC_ALLOC], op_count[FUNC_BIND],
               op_count[FUNC_RELEASE], op_count[FUNC_FIND]);
      $display("testbench: %0d full-table refusals, %0d failed lookups, 5 base settings",
               full_count, miss_count);
      if (errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

// ----- stack_slot_allocator_top.f -----
rtl/ssa_pkg.sv
rtl/ssa_slot_ram.sv
rtl/ssa_addr_gen.sv
rtl/ssa_seq.sv
rtl/stack_slot_allocator_top.sv
tb/testbench.sv
